[hdl/gcne_pkg.sv]
package gcne_pkg;

    localparam int COORD_W = 16;
    localparam int SIZE_W  = 15;
    localparam int INDEX_W = 30;
    localparam int KIND_W  = 4;
    localparam int NBR_N   = 9;
    localparam int CFG_AW  = 2;

    localparam logic [CFG_AW-1:0] CFG_MAP_WIDTH   = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_MAP_HEIGHT  = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_CELL_WIDTH  = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_CELL_HEIGHT = 2'd3;

    localparam logic [SIZE_W-1:0] MAP_WIDTH_RST   = 15'd256;
    localparam logic [SIZE_W-1:0] MAP_HEIGHT_RST  = 15'd256;
    localparam logic [SIZE_W-1:0] CELL_WIDTH_RST  = 15'd16;
    localparam logic [SIZE_W-1:0] CELL_HEIGHT_RST = 15'd16;

    typedef enum logic [KIND_W-1:0] {
        KIND_CENTRE     = 4'd0,
        KIND_LEFT       = 4'd1,
        KIND_RIGHT      = 4'd2,
        KIND_UP         = 4'd3,
        KIND_DOWN       = 4'd4,
        KIND_UP_LEFT    = 4'd5,
        KIND_UP_RIGHT   = 4'd6,
        KIND_DOWN_LEFT  = 4'd7,
        KIND_DOWN_RIGHT = 4'd8
    } kind_t;

    // One query ready for enumeration: centre cell, row pitch, and the cells that exist.
    typedef struct packed {
        logic [INDEX_W-1:0] centre;
        logic [SIZE_W-1:0]  cols;
        logic [NBR_N-1:0]   mask;
    } item_t;

    function automatic logic [SIZE_W-1:0] at_least_one(input logic [SIZE_W-1:0] v);
        at_least_one = (v == '0) ? {{(SIZE_W-1){1'b0}}, 1'b1} : v;
    endfunction

endpackage

[hdl/gcne_div.sv]
module gcne_div #(
    parameter int W = 16,
    parameter int L = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  logic [L-1:0][W-1:0]   num,
    input  logic [L-1:0][W-2:0]   den,
    output logic                  out_valid,
    output logic [L-1:0][W-1:0]   quo
);

    // One quotient bit per stage, most significant first.
    logic [W-1:0]               valid_reg;
    logic [L-1:0][W-1:0]        num_reg  [W];
    logic [L-1:0][W-2:0]        rem_reg  [W];
    logic [L-1:0][W-1:0]        q_reg    [W];
    logic [L-1:0][W-1:0]        num_next [W];
    logic [L-1:0][W-2:0]        rem_next [W];
    logic [L-1:0][W-1:0]        q_next   [W];

    for (genvar s = 0; s < W; s++) begin : g_stage
        for (genvar l = 0; l < L; l++) begin : g_lane
            logic [W-1:0] src_num;
            logic [W-2:0] src_rem;
            logic [W-1:0] src_q;
            logic [W-1:0] trial;
            logic [W-1:0] diff;
            logic         ge;
            if (s == 0) begin : g_first
                assign src_num = num[l];
                assign src_rem = '0;
                assign src_q   = '0;
            end else begin : g_rest
                assign src_num = num_reg[s-1][l];
                assign src_rem = rem_reg[s-1][l];
                assign src_q   = q_reg[s-1][l];
            end
            assign trial = {src_rem, src_num[W-1]};
            assign ge    = trial >= {1'b0, den[l]};
            assign diff  = trial - {1'b0, den[l]};
            assign rem_next[s][l] = ge ? diff[W-2:0] : trial[W-2:0];
            assign num_next[s][l] = {src_num[W-2:0], 1'b0};
            assign q_next[s][l]   = {src_q[W-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[s] <= num_next[s];
                rem_reg[s] <= rem_next[s];
                q_reg[s]   <= q_next[s];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[W-2:0], in_valid};
        end
    end

    assign out_valid = valid_reg[W-1];
    assign quo       = q_reg[W-1];

endmodule

[hdl/gcne_emit.sv]
module gcne_emit (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  gcne_pkg::item_t            in_item,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [gcne_pkg::INDEX_W-1:0] out_index,
    output logic [gcne_pkg::KIND_W-1:0]  out_kind,
    output logic                       out_last
);
    import gcne_pkg::*;

    logic [INDEX_W-1:0] centre_reg;
    logic [SIZE_W-1:0]  cols_reg;
    logic [NBR_N-1:0]   mask_reg;
    logic               out_valid_reg;
    logic [INDEX_W-1:0] index_reg;
    kind_t              kind_reg;
    logic               last_reg;

    logic               out_free;
    logic               fire;
    logic               load;
    logic [NBR_N-1:0]   sel;
    logic [NBR_N-1:0]   rest;
    kind_t              kind_next;
    logic [INDEX_W:0]   hoff;
    logic [INDEX_W:0]   voff;
    logic [INDEX_W:0]   sum;

    assign out_free = !out_valid_reg || out_ready;
    assign fire     = out_free && (mask_reg != '0);
    assign sel      = mask_reg & (~mask_reg + 1'b1);
    assign rest     = mask_reg & ~sel;
    assign in_ready = (mask_reg == '0) || (out_free && $onehot(mask_reg));
    assign load     = in_valid && in_ready;

    always_comb
    begin
        kind_next = KIND_CENTRE;
        hoff      = '0;
        voff      = '0;
        case (sel)
            9'b000000001: kind_next = KIND_CENTRE;
            9'b000000010: kind_next = KIND_LEFT;
            9'b000000100: kind_next = KIND_RIGHT;
            9'b000001000: kind_next = KIND_UP;
            9'b000010000: kind_next = KIND_DOWN;
            9'b000100000: kind_next = KIND_UP_LEFT;
            9'b001000000: kind_next = KIND_UP_RIGHT;
            9'b010000000: kind_next = KIND_DOWN_LEFT;
            9'b100000000: kind_next = KIND_DOWN_RIGHT;
            default:      kind_next = KIND_CENTRE;
        endcase
        case (kind_next)
            KIND_LEFT, KIND_UP_LEFT, KIND_DOWN_LEFT:    hoff = '1;
            KIND_RIGHT, KIND_UP_RIGHT, KIND_DOWN_RIGHT: hoff = {{INDEX_W{1'b0}}, 1'b1};
            default:                                    hoff = '0;
        endcase
        case (kind_next)
            KIND_UP, KIND_UP_LEFT, KIND_UP_RIGHT:
                voff = ~{{(INDEX_W+1-SIZE_W){1'b0}}, cols_reg} + 1'b1;
            KIND_DOWN, KIND_DOWN_LEFT, KIND_DOWN_RIGHT:
                voff = {{(INDEX_W+1-SIZE_W){1'b0}}, cols_reg};
            default:
                voff = '0;
        endcase
    end

    assign sum = {1'b0, centre_reg} + hoff + voff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                mask_reg <= in_item.mask;
            end
            else if (fire)
            begin
                mask_reg <= rest;
            end
            if (out_free)
            begin
                out_valid_reg <= fire;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            centre_reg <= in_item.centre;
            cols_reg   <= in_item.cols;
        end
        if (fire)
        begin
            index_reg <= sum[INDEX_W-1:0];
            kind_reg  <= kind_next;
            last_reg  <= (rest == '0);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = index_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;

    a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("pending cell not presented");

    a_load_centre: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> mask_reg[0])
        else $error("new query lost its centre cell");

    a_last_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_free && $onehot(mask_reg)) |=> (out_valid_reg && last_reg))
        else $error("final cell of a query not marked last");

endmodule

[hdl/grid_cell_neighbour_enumerator.sv]
// Uniform-grid 3x3 neighbourhood enumerator.
// Input stream s_*: one query item per handshake, pos_x and pos_y signed.
// Output stream m_*: one item per emitted cell: the centre cell first, then the
// existing neighbours left, right, up, down, up-left, up-right, down-left,
// down-right; tlast marks the final cell of each query.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 map width,
// 1 map height, 2 cell width, 3 cell height) at the clock edge; a zero value
// acts as one. Write only while no query is in flight.
// Path from input accept to the centre cell on m_tvalid: the clamp register
// at the accept edge, a 16-stage one-bit-per-stage divider, a multiply stage,
// an add stage, the enumerator load, then the output register.
// Throughput: a query occupies the output for 1 to 9 items, one per emitted
// cell; the pipeline takes a new query every cycle while the enumerator can
// accept; fed steadily with m_tready high, the output gives one item per cycle.
// The pipeline holds whenever its last stage waits for the enumerator, which is
// busy while a query has more than one cell left or its last cell waits on a low
// m_tready; s_tready then drops and nothing is lost or repeated. Reset clears
// all valid bits and loads the default registers (256 x 256 map, 16 x 16 cells).
module grid_cell_neighbour_enumerator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [31:0]                    s_tdata,   // pos_x [15:0], pos_y [31:16]
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [31:0]                    m_tdata,   // cell_index [29:0], zero [31:30]
    output logic [gcne_pkg::KIND_W-1:0]    m_tuser,   // neighbour_kind [3:0]
    output logic                           m_tlast,
    input  logic                           cfg_we,
    input  logic [gcne_pkg::CFG_AW-1:0]    cfg_addr,
    input  logic [gcne_pkg::SIZE_W-1:0]    cfg_wdata
);
    import gcne_pkg::*;

    localparam int DW = SIZE_W + 1;

    logic [SIZE_W-1:0] map_w_reg;
    logic [SIZE_W-1:0] map_h_reg;
    logic [SIZE_W-1:0] cell_w_reg;
    logic [SIZE_W-1:0] cell_h_reg;
    logic [SIZE_W-1:0] mw;
    logic [SIZE_W-1:0] mh;
    logic [SIZE_W-1:0] cw;
    logic [SIZE_W-1:0] ch;

    logic              adv;
    logic              emit_ready;

    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic [SIZE_W-1:0] x_next;
    logic [SIZE_W-1:0] y_next;
    logic              s1_valid_reg;
    logic [SIZE_W-1:0] x_reg;
    logic [SIZE_W-1:0] y_reg;

    logic [3:0][DW-1:0]   div_num;
    logic [3:0][DW-2:0]   div_den;
    logic [3:0][DW-1:0]   div_quo;
    logic                 div_valid;

    logic                  m1_valid_reg;
    logic [INDEX_W-1:0]    prod_reg;
    logic [SIZE_W-1:0]     cx_reg;
    logic [SIZE_W-1:0]     cy_reg;
    logic [SIZE_W-1:0]     cols_reg;
    logic [SIZE_W-1:0]     rows_reg;

    logic                  m2_valid_reg;
    item_t                 item_reg;
    item_t                 item_next;
    logic                  has_l;
    logic                  has_r;
    logic                  has_u;
    logic                  has_d;
    logic [INDEX_W-1:0]    emit_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_w_reg  <= MAP_WIDTH_RST;
            map_h_reg  <= MAP_HEIGHT_RST;
            cell_w_reg <= CELL_WIDTH_RST;
            cell_h_reg <= CELL_HEIGHT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAP_WIDTH:   map_w_reg  <= cfg_wdata;
                CFG_MAP_HEIGHT:  map_h_reg  <= cfg_wdata;
                CFG_CELL_WIDTH:  cell_w_reg <= cfg_wdata;
                CFG_CELL_HEIGHT: cell_h_reg <= cfg_wdata;
                default:         map_w_reg  <= map_w_reg;
            endcase
        end
    end

    assign mw = at_least_one(map_w_reg);
    assign mh = at_least_one(map_h_reg);
    assign cw = at_least_one(cell_w_reg);
    assign ch = at_least_one(cell_h_reg);

    // The whole pipeline moves as one; it stops only when the enumerator is full.
    assign adv      = !m2_valid_reg || emit_ready;
    assign s_tready = adv;

    assign pos_x = s_tdata[15:0];
    assign pos_y = s_tdata[31:16];

    always_comb
    begin
        if (pos_x[COORD_W-1])
            x_next = '0;
        else if (pos_x[SIZE_W-1:0] > mw - 1'b1)
            x_next = mw - 1'b1;
        else
            x_next = pos_x[SIZE_W-1:0];
        if (pos_y[COORD_W-1])
            y_next = '0;
        else if (pos_y[SIZE_W-1:0] > mh - 1'b1)
            y_next = mh - 1'b1;
        else
            y_next = pos_y[SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
        end
    end

    // Lanes: column of x, row of y, column count, row count (ceilings).
    assign div_num[0] = {1'b0, x_reg};
    assign div_num[1] = {1'b0, y_reg};
    assign div_num[2] = {1'b0, mw} + {1'b0, cw} - 1'b1;
    assign div_num[3] = {1'b0, mh} + {1'b0, ch} - 1'b1;
    assign div_den[0] = cw;
    assign div_den[1] = ch;
    assign div_den[2] = cw;
    assign div_den[3] = ch;

    gcne_div #(
        .W (DW),
        .L (4)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (s1_valid_reg),
        .num       (div_num),
        .den       (div_den),
        .out_valid (div_valid),
        .quo       (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m1_valid_reg <= 1'b0;
            m2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m1_valid_reg <= div_valid;
            m2_valid_reg <= m1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= {{(INDEX_W-SIZE_W){1'b0}}, div_quo[1][SIZE_W-1:0]}
                        * {{(INDEX_W-SIZE_W){1'b0}}, div_quo[2][SIZE_W-1:0]};
            cx_reg   <= div_quo[0][SIZE_W-1:0];
            cy_reg   <= div_quo[1][SIZE_W-1:0];
            cols_reg <= div_quo[2][SIZE_W-1:0];
            rows_reg <= div_quo[3][SIZE_W-1:0];
            item_reg <= item_next;
        end
    end

    assign has_l = cx_reg != '0;
    assign has_r = ({1'b0, cx_reg} + 1'b1) < {1'b0, cols_reg};
    assign has_u = cy_reg != '0;
    assign has_d = ({1'b0, cy_reg} + 1'b1) < {1'b0, rows_reg};

    always_comb
    begin
        item_next.centre = prod_reg + {{(INDEX_W-SIZE_W){1'b0}}, cx_reg};
        item_next.cols   = cols_reg;
        item_next.mask   = {has_r & has_d, has_l & has_d, has_r & has_u, has_l & has_u,
                            has_d, has_u, has_r, has_l, 1'b1};
    end

    gcne_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (m2_valid_reg),
        .in_ready  (emit_ready),
        .in_item   (item_reg),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (emit_index),
        .out_kind  (m_tuser),
        .out_last  (m_tlast)
    );

    assign m_tdata = {2'b00, emit_index};

endmodule
